>>> rtl/sjis_pkg.sv
// Shared types, codes, constants and the full-width conversion table.
package sjis_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int GLYPH_ROWS_DEF  = 7;

  localparam logic [15:0] FALLBACK_CODE = 16'h81A0;

  // input modes
  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_CODE  = 2'd1;
  localparam logic [1:0] MODE_GLYPH = 2'd2;

  // result status
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_SUBST = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // configuration register indexes
  localparam logic CFG_CONVERT = 1'b0;
  localparam logic CFG_ENTRIES = 1'b1;

  localparam int CFG_W = 10;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic start;       // set up a search
    logic fallback;    // search for the fallback code
    logic probe;       // read the code table at the probe position
    logic compare;     // narrow the window from the read entry
    logic glyph_base;  // latch glyph base from the hit position
    logic glyph_rd;    // read next glyph row
    logic load_out;    // move result into the output register
  } sjis_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_lookup;   // accepted byte completes a character
    logic go_trunc;    // accepted NUL cuts off a held lead byte
    logic empty;       // no entries to search
    logic hit;
    logic last;        // probe window exhausted
    logic rows_last;   // last glyph row being read
    logic out_free;
  } sjis_stat_t;

  localparam logic [15:0] WIDE_MAP [158] = '{
    16'h8140,16'h8149,16'h8168,16'h8194,16'h8190,16'h8193,16'h8195,16'h8166,
    16'h8169,16'h816A,16'h8196,16'h817B,16'h8143,16'h817C,16'h8144,16'h815E,
    16'h824F,16'h8250,16'h8251,16'h8252,16'h8253,16'h8254,16'h8255,16'h8256,
    16'h8257,16'h8258,16'h8146,16'h8147,16'h8183,16'h8181,16'h8184,16'h8148,
    16'h8197,16'h8260,16'h8261,16'h8262,16'h8263,16'h8264,16'h8265,16'h8266,
    16'h8267,16'h8268,16'h8269,16'h826A,16'h826B,16'h826C,16'h826D,16'h826E,
    16'h826F,16'h8270,16'h8271,16'h8272,16'h8273,16'h8274,16'h8275,16'h8276,
    16'h8277,16'h8278,16'h8279,16'h816D,16'h818F,16'h816E,16'h814F,16'h8151,
    16'h8165,16'h8281,16'h8282,16'h8283,16'h8284,16'h8285,16'h8286,16'h8287,
    16'h8288,16'h8289,16'h828A,16'h828B,16'h828C,16'h828D,16'h828E,16'h828F,
    16'h8290,16'h8291,16'h8292,16'h8293,16'h8294,16'h8295,16'h8296,16'h8297,
    16'h8298,16'h8299,16'h829A,16'h816F,16'h8162,16'h8170,16'h8160,16'h8142,
    16'h8175,16'h8176,16'h8141,16'h8145,16'h8392,16'h8340,16'h8342,16'h8344,
    16'h8346,16'h8348,16'h8383,16'h8385,16'h8387,16'h8362,16'h815B,16'h8341,
    16'h8343,16'h8345,16'h8347,16'h8349,16'h834A,16'h834C,16'h834E,16'h8350,
    16'h8352,16'h8354,16'h8356,16'h8358,16'h835A,16'h835C,16'h835E,16'h8360,
    16'h8363,16'h8365,16'h8367,16'h8369,16'h836A,16'h836B,16'h836C,16'h836D,
    16'h836E,16'h8371,16'h8374,16'h8377,16'h837A,16'h837D,16'h837E,16'h8380,
    16'h8381,16'h8382,16'h8384,16'h8386,16'h8388,16'h8389,16'h838A,16'h838B,
    16'h838C,16'h838D,16'h838F,16'h8393,16'h814A,16'h814B
  };

  function automatic logic is_lead(input logic [7:0] c);
    return (c >= 8'h81 && c <= 8'h9F) || (c >= 8'hE0 && c <= 8'hFC);
  endfunction

  function automatic logic [15:0] to_full_width(input logic [15:0] c);
    logic [7:0] lo;
    lo = c[7:0];
    if (c[15:8] == 8'h00 && lo >= 8'h20 && lo <= 8'h7E) begin
      return WIDE_MAP[8'(lo - 8'h20)];
    end
    if (c[15:8] == 8'h00 && lo >= 8'hA1 && lo <= 8'hDF) begin
      return WIDE_MAP[8'(lo - 8'hA1 + 8'd95)];
    end
    return c;
  endfunction

endpackage

>>> rtl/sjis_glyph_lookup_core.sv
// Top level: Shift-JIS byte stream to 7-row glyph lookup.
//
//  channel | handshake          | carries
//  in      | in_valid/in_ready  | mode, text byte, or a code table / glyph row write
//  out     | out_valid/out_ready| char code, status, packed glyph rows
//  cfg     | cfg_we             | convert_half_width (0), entries_in_use (1)
//
//  Load items and bytes that finish no character leave the sequencer idle; a cut-off lead
//  goes straight to the result. A character is transferred, then searched by binary search
//  (probes of a table read then a compare, at most 10 probes for 512 entries), searched again
//  for the fallback code on a miss, its rows read on a hit, and loaded into the output.
//  Reset is synchronous and needs no clearing pass; the tables are undefined until loaded.
//  A stalled result sits in the output register while the next bytes are taken.
module sjis_glyph_lookup_core #(
  parameter int TABLE_DEPTH = sjis_pkg::TABLE_DEPTH_DEF,
  parameter int GLYPH_ROWS  = sjis_pkg::GLYPH_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sjis_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_mode,
  input  logic [7:0]                 in_text_byte,
  input  logic [8:0]                 in_entry_index,
  input  logic [2:0]                 in_row_index,
  input  logic [15:0]                in_table_code,
  input  logic [7:0]                 in_glyph_row,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                out_char_code,
  output logic [1:0]                 out_status,
  output logic [55:0]                out_glyph_rows
);

  sjis_pkg::sjis_cmd_t  cmd;
  sjis_pkg::sjis_stat_t st;

  sjis_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd_o    (cmd),
    .st_i     (st)
  );

  sjis_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .GLYPH_ROWS  (GLYPH_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_mode        (in_mode),
    .in_text_byte   (in_text_byte),
    .in_entry_index (in_entry_index),
    .in_row_index   (in_row_index),
    .in_table_code  (in_table_code),
    .in_glyph_row   (in_glyph_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_code  (out_char_code),
    .out_status     (out_status),
    .out_glyph_rows (out_glyph_rows),
    .cmd_i          (cmd),
    .st_o           (st)
  );

endmodule

>>> rtl/sjis_ctrl.sv
// Sequencer for byte intake, binary searches, glyph row reads and result hand-off.
module sjis_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output sjis_pkg::sjis_cmd_t cmd_o,
  input  sjis_pkg::sjis_stat_t st_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PROBE,
    S_CMP,
    S_GLYPH,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   fb_r, fb_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    fb_nxt    = fb_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        cmd_o.accept = in_valid;
        if (in_valid) begin
          if (st_i.go_lookup) begin
            state_nxt = S_START;
            fb_nxt    = 1'b0;
          end else if (st_i.go_trunc) begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_START: begin
        cmd_o.start    = 1'b1;
        cmd_o.fallback = fb_r;
        if (st_i.empty) begin
          // nothing to search: both lookups miss
          if (fb_r) begin
            state_nxt = S_RESULT;
          end else begin
            fb_nxt = 1'b1;
          end
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd_o.probe = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        if (st_i.hit) begin
          cmd_o.glyph_base = 1'b1;
          state_nxt        = S_GLYPH;
        end else if (st_i.last) begin
          if (fb_r) begin
            state_nxt = S_RESULT;
          end else begin
            fb_nxt    = 1'b1;
            state_nxt = S_START;
          end
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_GLYPH: begin
        cmd_o.glyph_rd = 1'b1;
        if (st_i.rows_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last row lands this cycle
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fb_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fb_r    <= fb_nxt;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load_out |-> st_i.out_free)
    else $error("result loaded over a pending output");

  a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && st_i.go_lookup) |=> (state_r == S_START && !fb_r))
    else $error("lookup did not start with the main search");

  a_hit_reads_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && st_i.hit) |=> (state_r == S_GLYPH))
    else $error("search hit did not read glyph rows");

  a_busy_after_char: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (st_i.go_lookup || st_i.go_trunc)) |=> !in_ready)
    else $error("input taken while a character is in flight");

endmodule

>>> rtl/sjis_dp.sv
// Datapath: lead byte hold, conversion, code table and glyph store, search window, result.
module sjis_dp #(
  parameter int TABLE_DEPTH = sjis_pkg::TABLE_DEPTH_DEF,
  parameter int GLYPH_ROWS  = sjis_pkg::GLYPH_ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [sjis_pkg::CFG_W-1:0] cfg_wdata,
  input  logic [1:0]               in_mode,
  input  logic [7:0]               in_text_byte,
  input  logic [8:0]               in_entry_index,
  input  logic [2:0]               in_row_index,
  input  logic [15:0]              in_table_code,
  input  logic [7:0]               in_glyph_row,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              out_char_code,
  output logic [1:0]               out_status,
  output logic [55:0]              out_glyph_rows,
  input  sjis_pkg::sjis_cmd_t      cmd_i,
  output sjis_pkg::sjis_stat_t     st_o
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int GDEPTH  = TABLE_DEPTH * GLYPH_ROWS;
  localparam int GA_W    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int CNT_W   = ($clog2(TABLE_DEPTH + 1) > sjis_pkg::CFG_W) ?
                           $clog2(TABLE_DEPTH + 1) : sjis_pkg::CFG_W;
  localparam int EW      = ((IDX_W > 9) ? IDX_W : 9) + 1;
  localparam int NROWS   = (GLYPH_ROWS < 7) ? GLYPH_ROWS : 7;

  // configuration
  logic                      convert_r;
  logic [sjis_pkg::CFG_W-1:0] entries_r;

  // text state
  logic       lead_pending_r;
  logic [7:0] lead_byte_r;

  // lookup
  logic [15:0]      code_r;
  logic [15:0]      tgt_r;
  logic [1:0]       status_r;
  logic [IDX_W-1:0] lo_r, hi_r, pos_r;
  logic [GA_W-1:0]  base_r;
  logic [2:0]       rc_r;
  logic             cap_r;
  logic [2:0]       cap_row_r;
  logic [55:0]      glyph_r;

  // memories
  logic [15:0] code_mem [TABLE_DEPTH];
  logic [7:0]  glyph_mem [GDEPTH];
  logic [15:0] code_rd_r;
  logic [7:0]  glyph_rd_r;

  // output register
  logic        out_valid_r;
  logic [15:0] out_code_r;
  logic [1:0]  out_status_r;
  logic [55:0] out_glyph_r;

  logic             text_item, code_wr, glyph_wr;
  logic [EW-1:0]    entry_w;
  logic [IDX_W-1:0] entry_idx;
  logic [GA_W-1:0]  glyph_waddr, glyph_raddr;
  logic [15:0]      code_joined, code_conv;
  logic [CNT_W-1:0] cnt_ext, cnt;
  logic [IDX_W:0]   span;
  logic [IDX_W-1:0] pos_c;
  logic             gt;

  assign text_item = cmd_i.accept && (in_mode == sjis_pkg::MODE_TEXT);
  assign entry_w   = EW'(in_entry_index);
  assign entry_idx = entry_w[IDX_W-1:0];
  assign code_wr   = cmd_i.accept && (in_mode == sjis_pkg::MODE_CODE) &&
                     (entry_w < EW'(TABLE_DEPTH));
  assign glyph_wr  = cmd_i.accept && (in_mode == sjis_pkg::MODE_GLYPH) &&
                     (entry_w < EW'(TABLE_DEPTH)) && (5'(in_row_index) < 5'(GLYPH_ROWS));
  assign glyph_waddr = GA_W'(int'(entry_idx) * GLYPH_ROWS + int'(in_row_index));
  assign glyph_raddr = base_r + GA_W'(rc_r);

  assign code_joined = lead_pending_r ? {lead_byte_r, in_text_byte} : {8'h00, in_text_byte};
  assign code_conv   = convert_r ? sjis_pkg::to_full_width(code_joined) : code_joined;

  assign cnt_ext = CNT_W'(entries_r);
  assign cnt     = (cnt_ext > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cnt_ext;

  assign span  = {1'b0, hi_r} - {1'b0, lo_r} + (IDX_W+1)'(1);
  assign pos_c = lo_r + span[IDX_W:1];
  assign gt    = tgt_r > code_rd_r;

  always_comb begin
    st_o           = '0;
    st_o.go_lookup = lead_pending_r ? 1'b1
                     : (in_text_byte != 8'h00 && !sjis_pkg::is_lead(in_text_byte));
    st_o.go_lookup = st_o.go_lookup && (in_mode == sjis_pkg::MODE_TEXT) &&
                     !(lead_pending_r && in_text_byte == 8'h00);
    st_o.go_trunc  = (in_mode == sjis_pkg::MODE_TEXT) && lead_pending_r &&
                     (in_text_byte == 8'h00);
    st_o.empty     = (cnt == '0);
    st_o.hit       = (code_rd_r == tgt_r);
    st_o.last      = gt ? (pos_r == hi_r) : (pos_r == lo_r);
    st_o.rows_last = (rc_r == 3'(NROWS - 1));
    st_o.out_free  = !out_valid_r || out_ready;
  end

  // memories: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (code_wr) begin
      code_mem[entry_idx] <= in_table_code;
    end
    if (cmd_i.probe) begin
      code_rd_r <= code_mem[pos_c];
    end
  end

  always_ff @(posedge clk) begin
    if (glyph_wr) begin
      glyph_mem[glyph_waddr] <= in_glyph_row;
    end
    if (cmd_i.glyph_rd) begin
      glyph_rd_r <= glyph_mem[glyph_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      convert_r      <= 1'b0;
      entries_r      <= sjis_pkg::CFG_W'(512);
      lead_pending_r <= 1'b0;
      lead_byte_r    <= 8'h00;
      cap_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == sjis_pkg::CFG_CONVERT) begin
        convert_r <= cfg_wdata[0];
      end
      if (cfg_we && cfg_index == sjis_pkg::CFG_ENTRIES) begin
        entries_r <= cfg_wdata;
      end
      if (text_item) begin
        if (lead_pending_r) begin
          lead_pending_r <= 1'b0;
        end else if (in_text_byte != 8'h00 && sjis_pkg::is_lead(in_text_byte)) begin
          lead_pending_r <= 1'b1;
          lead_byte_r    <= in_text_byte;
        end
      end
      cap_r <= cmd_i.glyph_rd;
      if (cmd_i.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (text_item) begin
      glyph_r <= '0;
      if (st_o.go_trunc) begin
        code_r   <= {lead_byte_r, 8'h00};
        status_r <= sjis_pkg::ST_TRUNC;
      end else begin
        code_r   <= code_conv;
        status_r <= sjis_pkg::ST_FOUND;
      end
    end
    if (cmd_i.start) begin
      lo_r  <= '0;
      hi_r  <= IDX_W'(cnt - CNT_W'(1));
      tgt_r <= cmd_i.fallback ? sjis_pkg::FALLBACK_CODE : code_r;
      if (cmd_i.fallback) begin
        status_r <= sjis_pkg::ST_SUBST;
      end
    end
    if (cmd_i.probe) begin
      pos_r <= pos_c;
    end
    if (cmd_i.compare && !st_o.hit) begin
      if (gt) begin
        lo_r <= pos_r + IDX_W'(1);
      end else begin
        hi_r <= pos_r - IDX_W'(1);
      end
    end
    if (cmd_i.glyph_base) begin
      base_r <= GA_W'(int'(pos_r) * GLYPH_ROWS);
      rc_r   <= '0;
    end
    if (cmd_i.glyph_rd) begin
      rc_r      <= rc_r + 3'd1;
      cap_row_r <= rc_r;
    end
    if (cap_r) begin
      glyph_r[{cap_row_r, 3'b000} +: 8] <= glyph_rd_r;
    end
    if (cmd_i.load_out) begin
      out_code_r   <= code_r;
      out_status_r <= status_r;
      out_glyph_r  <= glyph_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_code  = out_code_r;
  assign out_status     = out_status_r;
  assign out_glyph_rows = out_glyph_r;

endmodule
